[rtl/mcg_pkg.sv]
// Shared types, constants and table functions for the month calendar grid.
package mcg_pkg;

	localparam int COLS         = 7;
	localparam int ROWS_DEFAULT = 6;
	localparam int ROW_W        = 4;
	localparam int COL_W        = 3;
	localparam int DAY_W        = 5;
	localparam int YEAR_W       = 14;
	localparam int MONTH_W      = 4;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   LEAP_FEB_LEN = 5'd29;

	typedef struct packed {
		logic [2:0]       first;
		logic [DAY_W-1:0] dim;
		logic [DAY_W-1:0] today;
	} mcg_month_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
			4'd2:                                         d = 5'd28;
			default:                                      d = 5'd0;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] month_off(input logic [MONTH_W-1:0] m);
		logic [2:0] o;
		case (m)
			4'd2:  o = 3'd3;
			4'd3:  o = 3'd2;
			4'd4:  o = 3'd5;
			4'd6:  o = 3'd3;
			4'd7:  o = 3'd5;
			4'd8:  o = 3'd1;
			4'd9:  o = 3'd4;
			4'd10: o = 3'd6;
			4'd11: o = 3'd2;
			4'd12: o = 3'd4;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

endpackage

[rtl/month_calendar_grid_top.sv]
// Month calendar grid: top level with stream ports.
// One transfer in (year, month, today's day) yields ROWS*7 cell transfers out, row-major,
// Sunday first, tlast on the final cell. The cell generator emits one cell per cycle while
// the output is not stalled. The weekday and month-length front end is a five-stage pipeline;
// when idle, a request passes through its stages, then the cell generator's month register
// and output register, before the first cell is offered. Requests queue in the pipeline while
// cells drain.
module month_calendar_grid_top #(
	parameter int ROWS = mcg_pkg::ROWS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // year[13:0], month[17:14], today_day[22:18], 0
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // row[3:0], column[6:4], day_number[11:7],
	                                    // in_month[12], is_today[13], 0
	output logic        m_axis_tlast    // last_cell
);

	logic                 pipe_valid, pipe_ready;
	mcg_pkg::mcg_month_t  pipe_month;

	logic [mcg_pkg::ROW_W-1:0] row;
	logic [mcg_pkg::COL_W-1:0] column;
	logic [mcg_pkg::DAY_W-1:0] day_number;
	logic                      in_month, is_today, last_cell;

	mcg_first_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.year      (s_axis_tdata[13:0]),
		.month     (s_axis_tdata[17:14]),
		.today_day (s_axis_tdata[22:18]),
		.out_valid (pipe_valid),
		.out_ready (pipe_ready),
		.out_month (pipe_month)
	);

	mcg_cell_gen #(
		.ROWS (ROWS)
	) u_cells (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (pipe_valid),
		.in_ready      (pipe_ready),
		.in_month      (pipe_month),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.row           (row),
		.column        (column),
		.day_number    (day_number),
		.in_month_flag (in_month),
		.is_today      (is_today),
		.last_cell     (last_cell)
	);

	assign m_axis_tdata = {2'b00, is_today, in_month, day_number, column, row};
	assign m_axis_tlast = last_cell;

endmodule

[rtl/mcg_first_pipe.sv]
// Five-stage pipeline giving weekday of the first and month length.
module mcg_first_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mcg_pkg::YEAR_W-1:0]        year,
	input  logic [mcg_pkg::MONTH_W-1:0]       month,
	input  logic [mcg_pkg::DAY_W-1:0]         today_day,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mcg_pkg::mcg_month_t               out_month
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic r1, r2, r3, r4, r5;

	assign r5 = !v_s5 || out_ready;
	assign r4 = !v_s4 || r5;
	assign r3 = !v_s3 || r4;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign in_ready = r1;

	// stage 1: shifted year, table lookups
	logic [14:0] yy_s1;
	logic [13:0] y_s1;
	logic [2:0]  off_s1;
	logic [4:0]  len_s1;
	logic        feb_s1, ok_s1;
	logic [4:0]  today_s1;

	// stage 2: reciprocal products
	logic [14:0] yy_s2;
	logic [13:0] y_s2;
	logic [2:0]  off_s2;
	logic [4:0]  len_s2;
	logic        feb_s2, ok_s2;
	logic [4:0]  today_s2;
	logic [23:0] p100_s2;
	logic [21:0] p400_s2;
	logic [29:0] py_s2;

	// stage 3: day count sum, month length
	logic [14:0] sum_s3;
	logic [4:0]  dim_s3;
	logic        ok_s3;
	logic [4:0]  today_s3;

	// stage 4: mod-7 product
	logic [14:0] sum_s4;
	logic [29:0] ps_s4;
	logic [4:0]  dim_s4;
	logic        ok_s4;
	logic [4:0]  today_s4;

	// stage 5: result
	mcg_pkg::mcg_month_t month_s5;

	logic [14:0] yy_c;
	logic [8:0]  q100_c;
	logic [6:0]  q400_c;
	logic [9:0]  q25_c;
	logic        r25_zero_c, leap_c;
	logic [14:0] sum_c;
	logic [12:0] q7_c;
	logic [14:0] rem7_c;

	always_comb begin
		yy_c = {1'b0, year} + 15'd400 - ((month < mcg_pkg::MONTH_MAR) ? 15'd1 : 15'd0);
		q100_c = p100_s2[23:15];
		q400_c = p400_s2[21:15];
		q25_c  = py_s2[29:20];
		r25_zero_c = ({1'b0, y_s2} == 15'(q25_c) * 15'd25);
		leap_c = (y_s2[1:0] == 2'd0 && !r25_zero_c) || (y_s2[3:0] == 4'd0 && r25_zero_c);
		sum_c = yy_s2 + {2'b0, yy_s2[14:2]} - {6'b0, q100_c} + {8'b0, q400_c}
			+ {12'b0, off_s2} + 15'd1;
		q7_c   = ps_s4[29:17];
		rem7_c = sum_s4 - 15'(q7_c) * 15'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
			if (r5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (r1 && in_valid) begin
			yy_s1    <= yy_c;
			y_s1     <= year;
			off_s1   <= mcg_pkg::month_off(month);
			len_s1   <= mcg_pkg::month_len(month);
			feb_s1   <= (month == mcg_pkg::MONTH_FEB);
			ok_s1    <= (month >= mcg_pkg::MONTH_JAN) && (month <= mcg_pkg::MONTH_DEC);
			today_s1 <= today_day;
		end
		if (r2 && v_s1) begin
			yy_s2    <= yy_s1;
			y_s2     <= y_s1;
			off_s2   <= off_s1;
			len_s2   <= len_s1;
			feb_s2   <= feb_s1;
			ok_s2    <= ok_s1;
			today_s2 <= today_s1;
			p100_s2  <= 24'(yy_s1[14:2]) * 24'd1311;
			p400_s2  <= 22'(yy_s1[14:4]) * 22'd1311;
			py_s2    <= 30'(y_s1) * 30'd41944;
		end
		if (r3 && v_s2) begin
			sum_s3   <= sum_c;
			dim_s3   <= (feb_s2 && leap_c) ? mcg_pkg::LEAP_FEB_LEN : len_s2;
			ok_s3    <= ok_s2;
			today_s3 <= today_s2;
		end
		if (r4 && v_s3) begin
			sum_s4   <= sum_s3;
			ps_s4    <= 30'(sum_s3) * 30'd18725;
			dim_s4   <= dim_s3;
			ok_s4    <= ok_s3;
			today_s4 <= today_s3;
		end
		if (r5 && v_s4) begin
			month_s5.first <= ok_s4 ? rem7_c[2:0] : 3'd0;
			month_s5.dim   <= dim_s4;
			month_s5.today <= today_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_month = month_s5;

	a_first_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> month_s5.first <= 3'd6)
		else $error("weekday of first out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !out_ready |=> v_s5 && $stable(month_s5))
		else $error("stalled stage 5 item lost or changed");

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> month_s5.dim == 5'd0 || month_s5.dim >= 5'd28)
		else $error("month length out of range");

endmodule

[rtl/mcg_cell_gen.sv]
// Cell generator: walks the grid one cell per cycle, while the output is not stalled, behind an output register.
module mcg_cell_gen #(
	parameter int ROWS = mcg_pkg::ROWS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  mcg_pkg::mcg_month_t          in_month,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mcg_pkg::ROW_W-1:0]    row,
	output logic [mcg_pkg::COL_W-1:0]    column,
	output logic [mcg_pkg::DAY_W-1:0]    day_number,
	output logic                         in_month_flag,
	output logic                         is_today,
	output logic                         last_cell
);

	localparam int NCELLS = ROWS * mcg_pkg::COLS;
	localparam int IW     = $clog2(NCELLS);

	logic                         busy_q;
	logic [IW-1:0]                idx_q;
	logic [mcg_pkg::ROW_W-1:0]    row_q;
	logic [mcg_pkg::COL_W-1:0]    col_q;
	mcg_pkg::mcg_month_t          month_q;

	logic                         ovalid_q;
	logic [mcg_pkg::ROW_W-1:0]    orow_q;
	logic [mcg_pkg::COL_W-1:0]    ocol_q;
	logic [mcg_pkg::DAY_W-1:0]    oday_q;
	logic                         oinm_q, otoday_q, olast_q;

	logic          out_free, emit, last, load, inm_c;
	logic [IW:0]   diff_c;
	logic [mcg_pkg::DAY_W-1:0] day_c;

	always_comb begin
		out_free = !ovalid_q || out_ready;
		emit     = busy_q && out_free;
		last     = (idx_q == IW'(NCELLS - 1));
		in_ready = !busy_q || (emit && last);
		load     = in_valid && in_ready;
		diff_c   = {1'b0, idx_q} - (IW + 1)'(month_q.first);
		inm_c    = ({1'b0, idx_q} >= (IW + 1)'(month_q.first))
			&& (diff_c < (IW + 1)'(month_q.dim));
		day_c    = inm_c ? (mcg_pkg::DAY_W'(diff_c) + 5'd1) : 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				row_q  <= '0;
				col_q  <= '0;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + IW'(1);
				if (col_q == mcg_pkg::COL_W'(mcg_pkg::COLS - 1)) begin
					col_q <= '0;
					row_q <= row_q + mcg_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + mcg_pkg::COL_W'(1);
				end
			end
			if (emit) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) month_q <= in_month;
		if (emit) begin
			orow_q   <= row_q;
			ocol_q   <= col_q;
			oday_q   <= day_c;
			oinm_q   <= inm_c;
			otoday_q <= inm_c && (day_c == month_q.today);
			olast_q  <= last;
		end
	end

	assign out_valid     = ovalid_q;
	assign row           = orow_q;
	assign column        = ocol_q;
	assign day_number    = oday_q;
	assign in_month_flag = oinm_q;
	assign is_today      = otoday_q;
	assign last_cell     = olast_q;

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && olast_q |-> orow_q == mcg_pkg::ROW_W'(ROWS - 1)
			&& ocol_q == mcg_pkg::COL_W'(mcg_pkg::COLS - 1))
		else $error("last cell mark at wrong grid position");

	a_empty_cell: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !oinm_q |-> oday_q == 5'd0 && !otoday_q)
		else $error("empty cell carries a day or today mark");

	a_counters: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q == IW'(row_q * mcg_pkg::COLS + col_q))
		else $error("cell index out of step with row and column");

endmodule
